FILE: rtl/multiplexed_adc_window_sum_assert.svh
// Assertion macros used by the sampler RTL.
`ifndef MULTIPLEXED_ADC_WINDOW_SUM_ASSERT_SVH
`define MULTIPLEXED_ADC_WINDOW_SUM_ASSERT_SVH

// Check that a condition holds in the same cycle as its trigger.
`define MAWS_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check that a condition holds in the cycle after its trigger.
`define MAWS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/maws_pkg.sv
`default_nettype none
package maws_pkg;

  localparam int NUM_CH          = 3;
  localparam int SUM_BITS        = 16;
  localparam int SAMPLE_DEPTH_DEF = 8;
  localparam int SAMPLE_BITS_DEF  = 10;
  localparam int IN_SAMPLE_BITS  = 10;

  // Item codes
  localparam logic MODE_SAMPLE = 1'b0;
  localparam logic MODE_QUERY  = 1'b1;

  // Channel codes
  localparam logic [1:0] CH_POT     = 2'd0;
  localparam logic [1:0] CH_TEMP    = 2'd1;
  localparam logic [1:0] CH_PRES    = 2'd2;
  localparam logic [1:0] CH_INVALID = 2'd3;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_WALK = 2'b10
  } state_t;

endpackage
`default_nettype wire

FILE: rtl/maws_cell.sv
`default_nettype none
// One slot of the sample ring: one entry per channel, each handed on to the
// next cell when its channel shifts.
module maws_cell #(
  parameter int SAMPLE_BITS = maws_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                        clk,
  input  logic                                        rst,
  input  logic [maws_pkg::NUM_CH-1:0]                 shift_en,
  input  logic [maws_pkg::NUM_CH-1:0][SAMPLE_BITS-1:0] din,
  output logic [maws_pkg::NUM_CH-1:0][SAMPLE_BITS-1:0] q
);
  import maws_pkg::*;

  // Advance each channel's entry independently
  always_ff @(posedge clk) begin
    if (rst) begin
      q <= '0;
    end else begin
      for (int c = 0; c < NUM_CH; c++) begin
        if (shift_en[c]) begin
          q[c] <= din[c];
        end
      end
    end
  end

endmodule
`default_nettype wire

FILE: rtl/maws_accum.sv
`default_nettype none
// Running sum for a window walk, wrapping at the sum width.
module maws_accum #(
  parameter int SAMPLE_BITS = maws_pkg::SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          clear,
  input  logic                          add_en,
  input  logic [SAMPLE_BITS-1:0]        addend,
  output logic [maws_pkg::SUM_BITS-1:0] sum
);
  import maws_pkg::*;

  // Clear at the start of a walk, then add one entry per cycle while add_en is high
  always_ff @(posedge clk) begin
    if (clear) begin
      sum <= '0;
    end else if (add_en) begin
      sum <= sum + SUM_BITS'(addend);
    end
  end

endmodule
`default_nettype wire

FILE: rtl/multiplexed_adc_window_sum.sv
`default_nettype none
// Channel  | Direction | Ports
// command  | in/out    | start, mode, sample, query_channel in; busy out
// result   | out       | done, written_channel, window_sum, next_channel
//
// A sample transfer shifts into the channel's row of cells; done pulses in the
// next cycle and busy stays low, so samples may come every cycle.
// A query rotates the channel's row once round the chain, one entry a cycle into
// the accumulator while busy is high; done pulses in the cycle after the last
// entry is added, and the next transfer can come once busy falls.
// Reset (rst, synchronous) clears all samples and the channel; the receiver cannot stall.
module multiplexed_adc_window_sum #(
  parameter int SAMPLE_DEPTH = maws_pkg::SAMPLE_DEPTH_DEF,
  parameter int SAMPLE_BITS  = maws_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  output logic                                 busy,
  input  logic                                 mode,
  input  logic [maws_pkg::IN_SAMPLE_BITS-1:0]  sample,
  input  logic [1:0]                           query_channel,
  output logic                                 done,
  output logic [1:0]                           written_channel,
  output logic [maws_pkg::SUM_BITS-1:0]        window_sum,
  output logic [1:0]                           next_channel
);
  import maws_pkg::*;

  `include "multiplexed_adc_window_sum_assert.svh"

  localparam int CNT_W = (SAMPLE_DEPTH > 1) ? $clog2(SAMPLE_DEPTH) : 1;

  state_t                                state;
  state_t                                state_next;
  logic [CNT_W-1:0]                      walk_cnt;
  logic [1:0]                            cur_ch;
  logic [1:0]                            q_ch;
  logic                                  show_sum;
  logic                                  accept;
  logic                                  take_sample;
  logic                                  take_query;
  logic                                  walk_last;
  logic                                  q_valid;
  logic [NUM_CH-1:0]                     shift_en;
  logic [NUM_CH-1:0][SAMPLE_BITS-1:0]    head_din;
  logic [NUM_CH-1:0][SAMPLE_BITS-1:0]    cell_q [SAMPLE_DEPTH];
  logic [SAMPLE_BITS-1:0]                tail_val;
  logic [SUM_BITS-1:0]                   acc_sum;

  assign busy        = (state == ST_WALK);
  assign accept      = start && !busy;
  assign take_sample = accept && (mode == MODE_SAMPLE);
  assign take_query  = accept && (mode == MODE_QUERY);
  assign walk_last   = (walk_cnt == CNT_W'(SAMPLE_DEPTH - 1));
  assign q_valid     = (q_ch != CH_INVALID);

  // Pick which channel rows advance this cycle
  always_comb begin
    shift_en = '0;
    if (take_sample && (cur_ch != CH_INVALID)) begin
      shift_en[cur_ch] = 1'b1;
    end else if (busy && q_valid) begin
      shift_en[q_ch] = 1'b1;
    end
  end

  // Feed the head cell: new sample on a transfer, else wrap the tail round
  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      head_din[c] = take_sample ? SAMPLE_BITS'(sample) : cell_q[SAMPLE_DEPTH-1][c];
    end
  end

  genvar i;
  generate
    for (i = 0; i < SAMPLE_DEPTH; i++) begin : g_cell
      maws_cell #(
        .SAMPLE_BITS(SAMPLE_BITS)
      ) u_cell (
        .clk      (clk),
        .rst      (rst),
        .shift_en (shift_en),
        .din      ((i == 0) ? head_din : cell_q[(i == 0) ? 0 : i - 1]),
        .q        (cell_q[i])
      );
    end
  endgenerate

  // Tail entry of the queried channel, zero for the invalid code
  assign tail_val = q_valid ? cell_q[SAMPLE_DEPTH-1][q_ch] : '0;

  maws_accum #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_accum (
    .clk    (clk),
    .clear  (take_query),
    .add_en (busy),
    .addend (tail_val),
    .sum    (acc_sum)
  );

  // Sequence the walk
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (take_query) state_next = ST_WALK;
      end
      ST_WALK: begin
        if (walk_last) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Hold control state, count walk steps, advance the channel
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      walk_cnt <= '0;
      cur_ch   <= CH_POT;
      done     <= 1'b0;
      show_sum <= 1'b0;
    end else begin
      state <= state_next;
      done  <= take_sample || (busy && walk_last);
      if (take_sample) begin
        show_sum <= 1'b0;
        priority if (cur_ch == CH_POT) cur_ch <= CH_TEMP;
        else if (cur_ch == CH_TEMP) cur_ch <= CH_PRES;
        else cur_ch <= CH_POT;
      end else if (busy && walk_last) begin
        show_sum <= 1'b1;
      end
      if (take_query) begin
        walk_cnt <= '0;
      end else if (busy) begin
        walk_cnt <= walk_cnt + 1'b1;
      end
    end
  end

  // Capture per-item payload for the result transfer
  always_ff @(posedge clk) begin
    if (take_query) begin
      q_ch            <= query_channel;
      written_channel <= CH_POT;
      next_channel    <= cur_ch;
    end else if (take_sample) begin
      written_channel <= cur_ch;
      priority if (cur_ch == CH_POT) next_channel <= CH_TEMP;
      else if (cur_ch == CH_TEMP) next_channel <= CH_PRES;
      else next_channel <= CH_POT;
    end
  end

  assign window_sum = show_sum ? acc_sum : '0;

  `MAWS_ASSERT_NEXT(a_sample_done, clk, rst, take_sample, done && !busy, "sample transfer without result")
  `MAWS_ASSERT_NEXT(a_query_walk, clk, rst, take_query, busy && (walk_cnt == '0), "query did not start walk")
  `MAWS_ASSERT_NOW(a_chan_valid, clk, rst, 1'b1, cur_ch != CH_INVALID, "current channel invalid")
  `MAWS_ASSERT_NEXT(a_walk_end, clk, rst, busy && walk_last, done && show_sum && !busy, "walk end without result")

endmodule
`default_nettype wire

FILE: tb/adc_window_checker.sv
`timescale 1ns / 1ps
module adc_window_checker #(
  parameter int SAMPLE_DEPTH = maws_pkg::SAMPLE_DEPTH_DEF,
  parameter int SAMPLE_BITS  = maws_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic                                busy,
  input  logic                                mode,
  input  logic [maws_pkg::IN_SAMPLE_BITS-1:0] sample,
  input  logic [1:0]                          query_channel,
  input  logic                                done,
  input  logic [1:0]                          written_channel,
  input  logic [maws_pkg::SUM_BITS-1:0]       window_sum,
  input  logic [1:0]                          next_channel,
  output int                                  fault_count,
  output int                                  outstanding
);
  import maws_pkg::*;

  typedef struct packed {
    logic [1:0]          wr_ch;
    logic [SUM_BITS-1:0] sum;
    logic [1:0]          nxt_ch;
  } adc_report_t;

  // Shadow copy of the per-channel ring buffers and the sequencer
  logic [SAMPLE_BITS-1:0] sample_rows [NUM_CH][SAMPLE_DEPTH];
  int unsigned            row_heads [NUM_CH];
  logic [1:0]             active_ch;
  adc_report_t            adc_reports [$];

  initial fault_count = 0;
  initial outstanding = 0;

  // Sum one channel's buffer, wrapping at the sum width
  function automatic logic [SUM_BITS-1:0] row_total(input logic [1:0] ch);
    logic [SUM_BITS-1:0] acc;
    acc = '0;
    if (ch == CH_INVALID) return '0;
    for (int i = 0; i < SAMPLE_DEPTH; i++) acc = acc + SUM_BITS'(sample_rows[ch][i]);
    return acc;
  endfunction

  // Apply one transfer to the shadow state and return the report it causes
  function automatic adc_report_t step_sampler(input logic m,
                                               input logic [IN_SAMPLE_BITS-1:0] s,
                                               input logic [1:0] q);
    adc_report_t r;
    r = '0;
    if (m == MODE_SAMPLE) begin
      if (active_ch != CH_INVALID) begin
        sample_rows[active_ch][row_heads[active_ch]] = SAMPLE_BITS'(s);
        row_heads[active_ch] = (row_heads[active_ch] + 1 >= SAMPLE_DEPTH) ?
                               0 : row_heads[active_ch] + 1;
      end
      r.wr_ch = active_ch;
      // pressure falls back to potentiometer
      active_ch = (active_ch == CH_POT || active_ch == CH_TEMP) ? active_ch + 2'd1 : CH_POT;
      r.nxt_ch = active_ch;
    end else begin
      r.sum    = row_total(q);
      r.nxt_ch = active_ch;
    end
    return r;
  endfunction

  function automatic bit field_ok(input string name, input int want, input int got);
    if (want == got) return 1'b1;
    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    return 1'b0;
  endfunction

  always @(posedge clk) begin
    adc_report_t want;
    bit ok;
    if (rst) begin
      foreach (sample_rows[c, i]) sample_rows[c][i] = '0;
      foreach (row_heads[c]) row_heads[c] = 0;
      active_ch = CH_POT;
      adc_reports.delete();
      outstanding <= 0;
    end else begin
      // Compare the result shown this cycle against the oldest report
      if (done) begin
        if (adc_reports.size() == 0) begin
          $display("%0t: result with none expected, actual wr=%0d sum=%0d next=%0d",
                   $time, written_channel, window_sum, next_channel);
          fault_count = fault_count + 1;
        end else begin
          want = adc_reports.pop_front();
          ok = field_ok("written_channel", want.wr_ch, written_channel);
          ok = field_ok("window_sum", want.sum, window_sum) && ok;
          ok = field_ok("next_channel", want.nxt_ch, next_channel) && ok;
          if (!ok) fault_count = fault_count + 1;
        end
      end
      // Queue the report for a transfer accepted at this edge
      if (start && !busy) adc_reports.push_back(step_sampler(mode, sample, query_channel));
      outstanding <= adc_reports.size();
    end
  end

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  import maws_pkg::*;

  localparam int DEPTH     = SAMPLE_DEPTH_DEF;
  localparam int BITS      = SAMPLE_BITS_DEF;
  localparam int RAND_ITEMS = 1280;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      start = 1'b0;
  logic                      mode = MODE_SAMPLE;
  logic [IN_SAMPLE_BITS-1:0] sample = '0;
  logic [1:0]                query_channel = CH_POT;
  logic                      busy;
  logic                      done;
  logic [1:0]                written_channel;
  logic [SUM_BITS-1:0]       window_sum;
  logic [1:0]                next_channel;
  int                        fault_count;
  int                        outstanding;
  bit                        steady = 1'b0;

  always #6 clk = ~clk;

  multiplexed_adc_window_sum #(.SAMPLE_DEPTH(DEPTH), .SAMPLE_BITS(BITS)) dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .mode(mode), .sample(sample),
    .query_channel(query_channel), .done(done), .written_channel(written_channel),
    .window_sum(window_sum), .next_channel(next_channel)
  );

  adc_window_checker #(.SAMPLE_DEPTH(DEPTH), .SAMPLE_BITS(BITS)) scoreboard (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .mode(mode), .sample(sample),
    .query_channel(query_channel), .done(done), .written_channel(written_channel),
    .window_sum(window_sum), .next_channel(next_channel),
    .fault_count(fault_count), .outstanding(outstanding)
  );

  // Hold start until the block takes the transfer
  task automatic issue(input logic m, input logic [IN_SAMPLE_BITS-1:0] s,
                       input logic [1:0] q);
    start         <= 1'b1;
    mode          <= m;
    sample        <= s;
    query_channel <= q;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Drop start for a random number of cycles, never while steady is set
  task automatic idle_gaps();
    while (!steady && $urandom_range(99) < 19) begin
      start <= 1'b0;
      @(posedge clk);
    end
  endtask

  // Stop sending until every queued result has come back
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  initial begin
    #2_000_000;
    $display("multiplexed_adc_window_sum verification failed");
    $finish;
  end

  initial begin
    logic [IN_SAMPLE_BITS-1:0] corner [12];
    logic [IN_SAMPLE_BITS-1:0] val;
    int                        pick;
    corner = '{10'h3FF, 10'h3FF, 10'h3FF, 10'h000, 10'h000, 10'h000,
               10'h2AA, 10'h155, 10'h2AA, 10'h155, 10'h001, 10'h200};
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Query every channel from reset, including the invalid one
    for (int c = 0; c < 4; c++) begin
      idle_gaps();
      issue(MODE_QUERY, 10'h3FF, 2'(c));
    end
    // Walk the round robin with extreme and alternating samples
    foreach (corner[i]) begin
      idle_gaps();
      issue(MODE_SAMPLE, corner[i], CH_INVALID);
    end
    for (int c = 3; c >= 0; c--) begin
      idle_gaps();
      issue(MODE_QUERY, 10'h000, 2'(c));
    end

    // Random mix: mostly samples so the rings wrap, queries between them
    for (int n = 0; n < RAND_ITEMS; n++) begin
      steady = (n >= 500 && n < 800);
      if (n == 250 || n == 1000) drain();
      pick = $urandom_range(99);
      if (pick < 15)      val = 10'h3FF;
      else if (pick < 25) val = 10'h000;
      else                val = 10'($urandom_range(1023));
      idle_gaps();
      issue(($urandom_range(99) < 62) ? MODE_SAMPLE : MODE_QUERY, val,
            2'($urandom_range(3)));
    end

    drain();
    repeat (2 * DEPTH + 4) @(posedge clk);
    if (fault_count == 0) begin
      $display("multiplexed_adc_window_sum verification clean");
    end else begin
      $display("multiplexed_adc_window_sum verification failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+rtl
rtl/maws_pkg.sv
rtl/maws_cell.sv
rtl/maws_accum.sv
rtl/multiplexed_adc_window_sum.sv
tb/adc_window_checker.sv
tb/tb_top.sv
